### hdl/logistic_loss_row_check_top_defines.svh
// Assertion macros for the logistic loss row check block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef LOGISTIC_LOSS_ROW_CHECK_TOP_DEFINES_SVH
`define LOGISTIC_LOSS_ROW_CHECK_TOP_DEFINES_SVH

// Same-cycle implication
`define LLRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LLRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/llrc_pkg.sv
// Shared types and constants of the logistic loss row check block.
// No dependencies; imported by the datapath, the controller and the top level.
`default_nettype none
package llrc_pkg;

  localparam int RESP_FRAC = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBJECT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 2'd2;

  typedef struct packed {
    logic signed [23:0] w_value;
    logic [16:0]        response;
    logic               recompute;
    logic               row_last;
    logic signed [23:0] param_value;
    logic signed [23:0] target_value;
    logic signed [39:0] best_value;
    logic signed [39:0] old_objective;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] objective;
    logic               fail_flag;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic acc_en;
    logic sq_en;
    logic plo_en;
    logic phi_en;
    logic div_start;
    logic div_pen;
    logic div_step;
    logic fin_load;
  } llrc_cmd_t;

  typedef struct packed {
    logic last;
    logic recompute;
    logic out_free;
  } llrc_status_t;

endpackage
`default_nettype wire

### hdl/llrc_stream_if.sv
// Valid/ready stream channel carrying one payload of type T.
// Payload types come from llrc_pkg.
`default_nettype none
interface llrc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/llrc_datapath.sv
// Datapath: softplus ROM, element term, loss accumulator, penalty product,
// shared shift-subtract divider and output register. Uses llrc_pkg.
`default_nettype none
module llrc_datapath #(
  parameter int SOFTPLUS_DEPTH = 1024,
  parameter int FRAC_BITS      = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  llrc_pkg::in_item_t    in_data_i,
  input  llrc_pkg::llrc_cmd_t   cmd_i,
  output llrc_pkg::llrc_status_t status_o,
  input  logic [15:0]           count_i,
  input  logic [23:0]           weight_i,
  input  logic [23:0]           tol_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output llrc_pkg::out_item_t   out_data_o
);
  import llrc_pkg::*;

  localparam int IDX_W  = $clog2(SOFTPLUS_DEPTH);
  localparam int SQ_W   = 49 - FRAC_BITS;
  localparam int SQH_W  = SQ_W - 24;
  localparam int PROD_W = SQ_W + 24;
  localparam int DVS_W  = 16 + FRAC_BITS;

  // Unsigned long division, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Softplus correction samples, worked out at elaboration
  function automatic logic [SOFTPLUS_DEPTH*24-1:0] build_rom();
    logic [63:0] term;
    logic [63:0] c;
    logic [63:0] e;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] s;
    logic [63:0] p;
    logic [63:0] ent;
    logic [SOFTPLUS_DEPTH*24-1:0] rom;
    term = 64'd1 << 30;
    c    = term;
    e    = term;
    rom  = '0;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64(term * 64'd16, 64'(SOFTPLUS_DEPTH) * 64'(k));
      if ((k & 1) == 1) c = c - term;
      else c = c + term;
    end
    for (int i = 0; i < SOFTPLUS_DEPTH; i++) begin
      z  = udiv64(e << 30, (64'd2 << 30) + e);
      z2 = (z * z) >> 30;
      s  = z;
      p  = z;
      for (int k = 1; k <= 14; k++) begin
        p = (p * z2) >> 30;
        s = s + udiv64(p, 64'(2 * k + 1));
      end
      ent = ((s << 1) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      rom[i*24 +: 24] = ent[23:0];
      e = (e * c + (64'd1 << 29)) >> 30;
    end
    return rom;
  endfunction

  localparam logic [SOFTPLUS_DEPTH*24-1:0] SP_ROM = build_rom();

  function automatic logic [39:0] sat40(input logic [41:0] v);
    logic [39:0] r;
    if (!v[41] && (v[40] || v[39])) r = 40'h7F_FFFF_FFFF;
    else if (v[41] && !(v[40] && v[39])) r = 40'h80_0000_0000;
    else r = v[39:0];
    return r;
  endfunction

  in_item_t           in_q;
  logic [23:0]        sp_q;
  logic               hit_q;
  logic [23:0]        wpos_q;
  logic signed [41:0] rw_q;
  logic [39:0]        loss_q, loss_d;
  logic [39:0]        lfin_q;
  logic [SQ_W-1:0]    sq_q;
  logic [47:0]        plo_q;
  logic [PROD_W-1:0]  p_q;
  logic [PROD_W-1:0]  dvd_q;
  logic [DVS_W:0]     rem_q;
  logic [DVS_W-1:0]   dvs_q;
  logic               neg_q;
  logic [40:0]        lq_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // Hold the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_data_i;
  end

  // Table lookup and response product
  logic [23:0]        abs_w;
  logic [40:0]        scaled;
  logic [40:0]        idx_full;
  logic [IDX_W-1:0]   idx;
  logic [31:0]        rom_base;
  logic signed [41:0] rw_prod;
  always_comb begin
    abs_w    = in_q.w_value[23] ? (~in_q.w_value + 24'd1) : in_q.w_value;
    scaled   = {17'b0, abs_w} * 41'(SOFTPLUS_DEPTH);
    idx_full = scaled >> (FRAC_BITS + 4);
    idx      = idx_full[IDX_W-1:0];
    rom_base = 32'(idx) * 32'd24;
    rw_prod  = $signed({1'b0, in_q.response}) * in_q.w_value;
  end

  always_ff @(posedge clk_i) begin
    sp_q   <= SP_ROM[rom_base +: 24];
    hit_q  <= (idx_full < 41'(SOFTPLUS_DEPTH));
    wpos_q <= in_q.w_value[23] ? 24'd0 : in_q.w_value;
    rw_q   <= rw_prod;
  end

  // Element term and saturating accumulate
  logic signed [41:0] rw_rnd;
  logic signed [41:0] term;
  logic [41:0]        sum;
  always_comb begin
    rw_rnd = (rw_q + (42'sd1 <<< (RESP_FRAC - 1))) >>> RESP_FRAC;
    term   = $signed({18'b0, wpos_q}) + $signed({18'b0, (hit_q ? sp_q : 24'd0)}) - rw_rnd;
    sum    = {{2{loss_q[39]}}, loss_q} + term;
    loss_d = in_q.recompute ? sat40(sum) : loss_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_q <= '0;
    end else if (cmd_i.acc_en) begin
      loss_q <= in_q.row_last ? 40'd0 : loss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en && in_q.row_last) lfin_q <= loss_d;
  end

  // Squared distance and weighted penalty product
  logic signed [24:0] delta;
  logic [23:0]        abs_d;
  logic [48:0]        sq_sum;
  logic [48:0]        sq_sh;
  logic [SQH_W+23:0]  phi;
  always_comb begin
    delta  = {in_q.param_value[23], in_q.param_value}
           - {in_q.target_value[23], in_q.target_value};
    abs_d  = delta[24] ? 24'(-delta) : delta[23:0];
    sq_sum = 49'(abs_d) * 49'(abs_d) + (49'd1 << (FRAC_BITS - 1));
    sq_sh  = sq_sum >> FRAC_BITS;
    phi    = sq_q[SQ_W-1:24] * weight_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en)  sq_q  <= sq_sh[SQ_W-1:0];
    if (cmd_i.plo_en) plo_q <= sq_q[23:0] * weight_i;
    if (cmd_i.phi_en) p_q   <= {phi, 24'b0} + PROD_W'(plo_q);
  end

  // Shared restoring divider, one quotient bit per step
  logic [15:0]      n_eff;
  logic [39:0]      abs_l;
  logic [40:0]      lmag;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  always_comb begin
    n_eff  = (count_i == 16'd0) ? 16'd1 : count_i;
    abs_l  = lfin_q[39] ? (~lfin_q + 40'd1) : lfin_q;
    lmag   = {1'b0, dvd_q[39:0]};
    rem_sh = {rem_q[DVS_W-1:0], dvd_q[PROD_W-1]};
    ge     = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      if (cmd_i.div_pen) begin
        lq_q  <= neg_q ? (~lmag + 41'd1) : lmag;
        dvd_q <= p_q;
        dvs_q <= {n_eff, {FRAC_BITS{1'b0}}};
      end else begin
        neg_q <= lfin_q[39];
        dvd_q <= PROD_W'(abs_l);
        dvs_q <= DVS_W'(n_eff);
      end
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      dvd_q <= {dvd_q[PROD_W-2:0], ge};
    end
  end

  // Objective, failure compare and output register
  logic [39:0]        pen;
  logic [39:0]        obj;
  logic signed [42:0] gap;
  always_comb begin
    pen = (dvd_q > PROD_W'(40'h7F_FFFF_FFFF)) ? 40'h7F_FFFF_FFFF : dvd_q[39:0];
    obj = in_q.recompute ? sat40({lq_q[40], lq_q} + {2'b0, pen}) : in_q.old_objective;
    gap = {{3{in_q.best_value[39]}}, in_q.best_value} - {{3{obj[39]}}, obj};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_load) begin
      out_q.objective <= obj;
      out_q.fail_flag <= (gap < -$signed({19'b0, tol_i}));
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;
  assign status_o.last      = in_q.row_last;
  assign status_o.recompute = in_q.recompute;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

### hdl/llrc_ctrl.sv
// Controller: sequences lookup, accumulate, penalty product, two divisions
// and the result load. Uses llrc_pkg command and status types.
`default_nettype none
module llrc_ctrl #(
  parameter int DIV_STEPS = 57
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  llrc_pkg::llrc_status_t status_i,
  output llrc_pkg::llrc_cmd_t    cmd_o
);
  import llrc_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LOOK   = 4'd1;
  localparam logic [3:0] ST_ACC    = 4'd2;
  localparam logic [3:0] ST_SQ     = 4'd3;
  localparam logic [3:0] ST_PLO    = 4'd4;
  localparam logic [3:0] ST_PHI    = 4'd5;
  localparam logic [3:0] ST_LDIV   = 4'd6;
  localparam logic [3:0] ST_PSTART = 4'd7;
  localparam logic [3:0] ST_PDIV   = 4'd8;
  localparam logic [3:0] ST_FIN    = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             cnt_end;

  assign cnt_end = (cnt_q == CNT_W'(DIV_STEPS - 1));

  // Advance the sequence
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      ST_LOOK: state_d = ST_ACC;
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (!status_i.last) state_d = ST_IDLE;
        else if (status_i.recompute) state_d = ST_SQ;
        else state_d = ST_FIN;
      end
      ST_SQ: begin
        cmd_o.sq_en = 1'b1;
        state_d     = ST_PLO;
      end
      ST_PLO: begin
        cmd_o.plo_en = 1'b1;
        state_d      = ST_PHI;
      end
      ST_PHI: begin
        cmd_o.phi_en    = 1'b1;
        cmd_o.div_start = 1'b1;
        cnt_d           = '0;
        state_d         = ST_LDIV;
      end
      ST_LDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_end) state_d = ST_PSTART;
      end
      ST_PSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_pen   = 1'b1;
        cnt_d           = '0;
        state_d         = ST_PDIV;
      end
      ST_PDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_end) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.fin_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

### hdl/logistic_loss_row_check_top.sv
// Sequence: an element that ends no row is looked up and accumulated; a row
// end that passes the old objective then loads the result; a recomputed row
// end first runs the penalty product and the shared divider, one quotient bit
// per cycle (loss quotient, then penalty quotient), before the result load.
// Input is taken only when idle; a row end waits for a free result register.
// Reset: registers to defaults, loss sum to zero; softplus table is a ROM.
`default_nettype none
`include "logistic_loss_row_check_top_defines.svh"
module logistic_loss_row_check_top #(
  parameter int SOFTPLUS_DEPTH = 1024,
  parameter int FRAC_BITS      = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  llrc_stream_if.sink                         in_if,
  llrc_stream_if.source                       out_if,
  input  logic                                cfg_we_i,
  input  logic [llrc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [23:0]                         cfg_data_i
);
  import llrc_pkg::*;

  localparam int DIV_STEPS = 73 - FRAC_BITS;

  logic [15:0]  count_q;
  logic [23:0]  weight_q;
  logic [23:0]  tol_q;
  llrc_cmd_t    cmd;
  llrc_status_t status;

  // Register writes; unknown index drops the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 16'd1;
      weight_q <= '0;
      tol_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SUBJECT_COUNT:  count_q  <= cfg_data_i[15:0];
        CFG_PENALTY_WEIGHT: weight_q <= cfg_data_i;
        CFG_TOLERANCE:      tol_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  llrc_ctrl #(.DIV_STEPS(DIV_STEPS)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_if.valid),
    .in_ready_o(in_if.ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  llrc_datapath #(
    .SOFTPLUS_DEPTH(SOFTPLUS_DEPTH),
    .FRAC_BITS     (FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_if.data),
    .cmd_i      (cmd),
    .status_o   (status),
    .count_i    (count_q),
    .weight_i   (weight_q),
    .tol_i      (tol_q),
    .out_ready_i(out_if.ready),
    .out_valid_o(out_if.valid),
    .out_data_o (out_if.data)
  );

  // An element accepted mid-row never makes a result appear next cycle
  `LLRC_ASSERT_NEXT(a_no_early_result,
    in_if.valid && in_if.ready && !in_if.data.row_last && !out_if.valid,
    !out_if.valid, "result without row end")
  // The block is busy right after a transaction
  `LLRC_ASSERT_NEXT(a_busy_after_accept, in_if.valid && in_if.ready, !in_if.ready,
    "input taken while busy")
  // No input is taken while a division runs
  `LLRC_ASSERT_SAME(a_div_blocks_input, cmd.div_step, !in_if.ready,
    "input ready during division")

endmodule
`default_nettype wire
